/* hw/rtl/ssq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sine-squared series unit.
// Holds the microcode format, the control program and the datapath widths.
// No dependencies.
package ssq_pkg;

    // Field widths of the streams and the configuration register
    localparam int X_W       = 32;
    localparam int OUT_W     = 31;
    localparam int CFG_W     = 9;
    localparam logic [CFG_W-1:0] TERM_COUNT_RST = 9'd500;

    // Fixed-point datapath widths
    localparam int SQ_W      = 63;   // x^2 in Q8.56, at most 2^62
    localparam int MAG_W     = 63;   // term magnitude, at most 2^63-1
    localparam int SUM_W     = 64;   // signed Q24.40 running sum
    localparam int ACC_W     = 126;  // magnitude times 2x^2
    localparam int FRAC_DROP = 56;   // product scaling back to Q24.40
    localparam int FIRST_SHIFT = 16; // Q8.56 to Q24.40
    localparam int OUT_SHIFT = 10;   // Q24.40 to Q2.30
    localparam logic [OUT_W-1:0] ONE_Q30 = 31'h4000_0000;

    // Divider: radix-16 restoring, four quotient bits per step
    localparam int DIV_NUM_W   = 72;
    localparam int DIV_RADIX   = 4;
    localparam int DIV_STEPS   = DIV_NUM_W / DIV_RADIX;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Divider control word
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQUARE,
        OP_INIT,
        OP_MUL_FIRST,
        OP_MUL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    // Branch condition of one microcode step
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_WAIT_IN,
        BR_EXIT,
        BR_DIV_LOOP,
        BR_ALWAYS,
        BR_WAIT_OUT
    } br_t;

    // Partial-product selectors (magnitude half, 2x^2 half)
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_LO_HI = 2'd1;
    localparam logic [1:0] MUL_HI_LO = 2'd2;
    localparam logic [1:0] MUL_HI_HI = 2'd3;

    // Program addresses
    typedef logic [3:0] pc_t;
    localparam pc_t PC_IDLE   = 4'd0;
    localparam pc_t PC_SQUARE = 4'd1;
    localparam pc_t PC_INIT   = 4'd2;
    localparam pc_t PC_TEST   = 4'd3;
    localparam pc_t PC_MUL0   = 4'd4;
    localparam pc_t PC_MUL1   = 4'd5;
    localparam pc_t PC_MUL2   = 4'd6;
    localparam pc_t PC_MUL3   = 4'd7;
    localparam pc_t PC_DIVLD  = 4'd8;
    localparam pc_t PC_DIV    = 4'd9;
    localparam pc_t PC_UPDATE = 4'd10;
    localparam pc_t PC_OUT    = 4'd11;

    typedef struct packed {
        op_t        op;
        logic [1:0] mul_sel;
        br_t        br;
        pc_t        target;
    } uword_t;

    // Control program
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t uw;
        case (pc)
            PC_IDLE:   uw = '{op: OP_LOAD,      mul_sel: MUL_LO_LO, br: BR_WAIT_IN,
                              target: PC_IDLE};
            PC_SQUARE: uw = '{op: OP_SQUARE,    mul_sel: MUL_LO_LO, br: BR_NEXT,
                              target: PC_IDLE};
            PC_INIT:   uw = '{op: OP_INIT,      mul_sel: MUL_LO_LO, br: BR_NEXT,
                              target: PC_IDLE};
            PC_TEST:   uw = '{op: OP_NOP,       mul_sel: MUL_LO_LO, br: BR_EXIT,
                              target: PC_OUT};
            PC_MUL0:   uw = '{op: OP_MUL_FIRST, mul_sel: MUL_LO_LO, br: BR_NEXT,
                              target: PC_IDLE};
            PC_MUL1:   uw = '{op: OP_MUL,       mul_sel: MUL_LO_HI, br: BR_NEXT,
                              target: PC_IDLE};
            PC_MUL2:   uw = '{op: OP_MUL,       mul_sel: MUL_HI_LO, br: BR_NEXT,
                              target: PC_IDLE};
            PC_MUL3:   uw = '{op: OP_MUL,       mul_sel: MUL_HI_HI, br: BR_NEXT,
                              target: PC_IDLE};
            PC_DIVLD:  uw = '{op: OP_DIV_LOAD,  mul_sel: MUL_LO_LO, br: BR_NEXT,
                              target: PC_IDLE};
            PC_DIV:    uw = '{op: OP_DIV_STEP,  mul_sel: MUL_LO_LO, br: BR_DIV_LOOP,
                              target: PC_IDLE};
            PC_UPDATE: uw = '{op: OP_UPDATE,    mul_sel: MUL_LO_LO, br: BR_ALWAYS,
                              target: PC_TEST};
            PC_OUT:    uw = '{op: OP_EMIT,      mul_sel: MUL_LO_LO, br: BR_WAIT_OUT,
                              target: PC_IDLE};
            default:   uw = '{op: OP_NOP,       mul_sel: MUL_LO_LO, br: BR_ALWAYS,
                              target: PC_IDLE};
        endcase
        return uw;
    endfunction

endpackage

/* hw/rtl/ssq_div.sv */
`timescale 1ns / 1ps
// Iterative radix-16 restoring divider for the term scaling by 1/(k(2k-1)).
// Depends on ssq_pkg for the dividend width, step count and control struct.
module ssq_div #(
    parameter int DW = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssq_pkg::div_ctrl_t            ctrl,
    input  logic [ssq_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [DW-1:0]                 divisor,
    output logic [ssq_pkg::DIV_NUM_W-1:0] quotient,
    output logic                          last
);
    import ssq_pkg::*;

    logic [DIV_NUM_W-1:0] dq_reg;
    logic [DIV_NUM_W-1:0] dq_next;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;

    // Four restoring steps: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        logic [DW:0]          t;
        logic [DW-1:0]        r;
        logic [DIV_NUM_W-1:0] q;
        r = rem_reg;
        q = dq_reg;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            t = {r, q[DIV_NUM_W-1]};
            q = {q[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t    = t - {1'b0, divisor};
                q[0] = 1'b1;
            end
            r = t[DW-1:0];
        end
        dq_next  = dq_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            dq_next  = dividend;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (ctrl.step)
        begin
            dq_next  = q;
            rem_next = r;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign quotient = dq_reg;
    assign last     = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

/* hw/rtl/sine_squared_series_unit.sv */
`timescale 1ns / 1ps
// Sine-squared by truncated Taylor series, run by a microcoded sequencer.
// Each term runs one exit test, four 32x32 partial products, a divider load,
// 18 radix-16 divider steps and one update; the divider loop sets the rate. With T terms
// summed (term_count clamped to 1 through MAX_TERMS, or fewer once a term reaches zero), the
// result is registered once the output register is free, and the next angle is taken only after that.
// Reset (rst_n low, asynchronous) returns to idle, drops the output word, sets term_count 500.
module sine_squared_series_unit #(
    parameter int MAX_TERMS = 500
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // angle stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // [31:0] x_angle
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata,  // [30:0] sine_squared, [31] zero
    // term_count register write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ssq_pkg::CFG_W-1:0] cfg_data      // [8:0] term_count
);
    import ssq_pkg::*;

    localparam int KW = $clog2(MAX_TERMS + 2);
    localparam int DW = $clog2((MAX_TERMS + 1) * (2 * MAX_TERMS + 1) + 1);

    // Control state
    pc_t              pc_reg;
    pc_t              pc_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CFG_W-1:0] term_count_reg;
    logic [CFG_W-1:0] term_count_next;

    // Datapath registers
    logic [X_W-1:0]   ax_reg,     ax_next;
    logic [KW-1:0]    n_reg,      n_next;
    logic [SQ_W-1:0]  sq_reg,     sq_next;
    logic [KW-1:0]    k_reg,      k_next;
    logic [DW-1:0]    d_reg,      d_next;
    logic [MAG_W-1:0] mag_reg,    mag_next;
    logic [SUM_W-1:0] sum_reg,    sum_next;
    logic [ACC_W-1:0] acc_reg,    acc_next;
    logic [63:0]      pp_reg,     pp_next;
    logic [1:0]       pp_sh_reg,  pp_sh_next;
    logic [OUT_W-1:0] out_reg,    out_next;

    uword_t               uw;
    logic                 in_fire;
    logic                 out_free;
    logic                 loop_exit;
    logic [63:0]          two_sq;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [ACC_W-1:0]     pp_shifted;
    logic [ACC_W-1:0]     acc_total;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_NUM_W-1:0] div_quotient;
    logic                 div_last;
    div_ctrl_t            div_ctrl;
    logic [MAG_W-1:0]     q_sat;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-OUT_SHIFT-1:0] out_wide;

    // Fetch the control word of the current step
    assign uw = ucode_rom(pc_reg);

    assign s_axis_tready = (uw.op == OP_LOAD);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign loop_exit     = (k_reg > n_reg) || (mag_reg == '0);
    assign cfg_ready     = 1'b1;

    // Operand selection for the partial products
    assign two_sq = {sq_reg, 1'b0};
    assign mul_a  = uw.mul_sel[1] ? {1'b0, mag_reg[MAG_W-1:32]} : mag_reg[31:0];
    assign mul_b  = uw.mul_sel[0] ? two_sq[63:32] : two_sq[31:0];

    // Align the held partial product and fold it into the accumulator
    assign pp_shifted   = {{(ACC_W-64){1'b0}}, pp_reg} << {pp_sh_reg, 5'b0};
    assign acc_total    = acc_reg + pp_shifted;
    assign div_dividend = {{(DIV_NUM_W-(ACC_W-FRAC_DROP)){1'b0}}, acc_total[ACC_W-1:FRAC_DROP]};

    assign div_ctrl.load = (uw.op == OP_DIV_LOAD);
    assign div_ctrl.step = (uw.op == OP_DIV_STEP);

    ssq_div #(
        .DW (DW)
    ) u_ssq_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (d_reg),
        .quotient (div_quotient),
        .last     (div_last)
    );

    // Clamp the new term and add it to the sum (odd k) or subtract it (even k), with saturation
    always_comb
    begin
        if (div_quotient[DIV_NUM_W-1:MAG_W] != '0)
        begin
            q_sat = {MAG_W{1'b1}};
        end
        else
        begin
            q_sat = div_quotient[MAG_W-1:0];
        end
        if (k_reg[0])
        begin
            sum_wide = {sum_reg[SUM_W-1], sum_reg} + {2'b00, q_sat};
        end
        else
        begin
            sum_wide = {sum_reg[SUM_W-1], sum_reg} - {2'b00, q_sat};
        end
        out_wide = sum_reg[SUM_W-1:OUT_SHIFT];
    end

    // Step sequencing
    always_comb
    begin
        pc_next = pc_reg;
        case (uw.br)
            BR_NEXT:     pc_next = pc_reg + 4'd1;
            BR_WAIT_IN:  pc_next = in_fire ? pc_reg + 4'd1 : pc_reg;
            BR_EXIT:     pc_next = loop_exit ? uw.target : pc_reg + 4'd1;
            BR_DIV_LOOP: pc_next = div_last ? pc_reg + 4'd1 : pc_reg;
            BR_ALWAYS:   pc_next = uw.target;
            BR_WAIT_OUT: pc_next = out_free ? uw.target : pc_reg;
            default:     pc_next = PC_IDLE;
        endcase
    end

    // Datapath next values, one operation per step
    always_comb
    begin
        ax_next         = ax_reg;
        n_next          = n_reg;
        sq_next         = sq_reg;
        k_next          = k_reg;
        d_next          = d_reg;
        mag_next        = mag_reg;
        sum_next        = sum_reg;
        acc_next        = acc_reg;
        pp_next         = pp_reg;
        pp_sh_next      = pp_sh_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg & ~m_axis_tready;
        term_count_next = cfg_valid ? cfg_data : term_count_reg;
        case (uw.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    ax_next = s_axis_tdata[X_W-1] ? X_W'(0) - s_axis_tdata : s_axis_tdata;
                    if (term_count_reg == '0)
                    begin
                        n_next = KW'(1);
                    end
                    else if (32'(term_count_reg) > MAX_TERMS)
                    begin
                        n_next = KW'(MAX_TERMS);
                    end
                    else
                    begin
                        n_next = KW'(term_count_reg);
                    end
                end
            end
            OP_SQUARE:
            begin
                sq_next = SQ_W'({32'b0, ax_reg} * {32'b0, ax_reg});
            end
            OP_INIT:
            begin
                mag_next = MAG_W'(sq_reg[SQ_W-1:FIRST_SHIFT]);
                sum_next = SUM_W'(sq_reg[SQ_W-1:FIRST_SHIFT]);
                k_next   = KW'(2);
                d_next   = DW'(6);
            end
            OP_MUL_FIRST:
            begin
                acc_next   = '0;
                pp_next    = mul_a * mul_b;
                pp_sh_next = {1'b0, uw.mul_sel[1]} + {1'b0, uw.mul_sel[0]};
            end
            OP_MUL:
            begin
                acc_next   = acc_total;
                pp_next    = mul_a * mul_b;
                pp_sh_next = {1'b0, uw.mul_sel[1]} + {1'b0, uw.mul_sel[0]};
            end
            OP_UPDATE:
            begin
                mag_next = q_sat;
                if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                begin
                    sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                               : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum_wide[SUM_W-1:0];
                end
                k_next = k_reg + KW'(1);
                d_next = d_reg + DW'({k_reg, 2'b01});
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sum_reg[SUM_W-1])
                    begin
                        out_next = '0;
                    end
                    else if (out_wide > {{(SUM_W-OUT_SHIFT-OUT_W){1'b0}}, ONE_Q30})
                    begin
                        out_next = ONE_Q30;
                    end
                    else
                    begin
                        out_next = out_wide[OUT_W-1:0];
                    end
                end
            end
            default:
            begin
                // divider load, divider steps and the exit test leave the datapath alone
            end
        endcase
    end

    // Hold program counter, output valid and the term count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= PC_IDLE;
            out_valid_reg  <= 1'b0;
            term_count_reg <= TERM_COUNT_RST;
        end
        else
        begin
            pc_reg         <= pc_next;
            out_valid_reg  <= out_valid_next;
            term_count_reg <= term_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        n_reg     <= n_next;
        sq_reg    <= sq_next;
        k_reg     <= k_next;
        d_reg     <= d_next;
        mag_reg   <= mag_next;
        sum_reg   <= sum_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        out_reg   <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

endmodule

/* hw/rtl/ssq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the sine-squared series unit, bound to its top level.
// Depends on ssq_pkg for the result ceiling.
module ssq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import ssq_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed or dropped while stalled");

    // Keep results within 0 through 1.0
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= {1'b0, ONE_Q30})
        else $error("result above 1.0");

    // Drop the result word once reset has been seen at an edge
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // Go busy right after taking an angle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second angle taken back to back");

    // Never raise a result in the cycle after an angle is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared too early");

endmodule

bind sine_squared_series_unit ssq_checker u_ssq_checker (.*);
